// ===== design/ldcr_pkg.sv =====
// Shared types, constants and codes for the LED dot circle rasterizer.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none
package ldcr_pkg;

  localparam int FB_WIDTH_DEF  = 256;
  localparam int FB_HEIGHT_DEF = 128;
  localparam int DOT_COLS_DEF  = 64;
  localparam int DOT_ROWS_DEF  = 32;

  localparam int PIX_W   = 24;
  localparam int ACC_W   = 40;
  localparam int COORD_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_X  = 2'd0,
    CFG_GAP_Y  = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_t;

  localparam logic [11:0] GAP_X_RST  = 12'd16;
  localparam logic [11:0] GAP_Y_RST  = 12'd16;
  localparam logic [7:0]  RADIUS_RST = 8'd32;

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_CENTRE = 13'b0000000000100,
    ST_RDC    = 13'b0000000001000,
    ST_MASK   = 13'b0000000010000,
    ST_RING   = 13'b0000000100000,
    ST_PLOT   = 13'b0000001000000,
    ST_ADDY   = 13'b0000010000000,
    ST_SUBX   = 13'b0000100000000,
    ST_CHK    = 13'b0001000000000,
    ST_NEXT   = 13'b0010000000000,
    ST_RDP    = 13'b0100000000000,
    ST_FIN    = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic       we;
    logic [2:0] be;
  } store_ctl_t;

endpackage
`default_nettype wire

// ===== design/ldcr_if.sv =====
// Handshake channel interfaces for requests, results and register writes.
// Uses ldcr_pkg for field widths.
`default_nettype none
interface ldcr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] dot_col;
  logic [4:0] dot_row;
  logic [7:0] pixel_x;
  logic [6:0] pixel_y;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       redraw_all;
  modport source (output valid, req_type, dot_col, dot_row, pixel_x, pixel_y,
                  blue, green, red, redraw_all, input ready);
  modport sink (input valid, req_type, dot_col, dot_row, pixel_x, pixel_y,
                blue, green, red, redraw_all, output ready);
endinterface

interface ldcr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_blue;
  logic [7:0] read_green;
  logic [7:0] read_red;
  logic [2:0] drawn_mask;
  logic       clipped;
  modport source (output valid, read_blue, read_green, read_red, drawn_mask,
                  clipped, input ready);
  modport sink (input valid, read_blue, read_green, read_red, drawn_mask,
                clipped, output ready);
endinterface

interface ldcr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ldcr_pkg::CFG_IDX_W-1:0]  index;
  logic [ldcr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/ldcr_store.sv =====
// Frame store: one write port with per-channel enables, one registered read.
// Uses ldcr_pkg for the pixel width and control struct.
`default_nettype none
module ldcr_store #(
  parameter int DEPTH  = ldcr_pkg::FB_WIDTH_DEF * ldcr_pkg::FB_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                         clk,
  input  ldcr_pkg::store_ctl_t        ctl,
  input  wire [ADDR_W-1:0]            waddr,
  input  wire [ldcr_pkg::PIX_W-1:0]   wdata,
  input  wire [ADDR_W-1:0]            raddr,
  output logic [ldcr_pkg::PIX_W-1:0]  rdata
);

  logic [ldcr_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      if (ctl.be[0]) mem[waddr][7:0]   <= wdata[7:0];
      if (ctl.be[1]) mem[waddr][15:8]  <= wdata[15:8];
      if (ctl.be[2]) mem[waddr][23:16] <= wdata[23:16];
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/ldcr_alu.sv =====
// Shared add/subtract unit for the circle recurrence and its compares.
// Uses ldcr_pkg for the accumulator type.
`default_nettype none
module ldcr_alu (
  input  ldcr_pkg::acc_t  a,
  input  ldcr_pkg::acc_t  b,
  input  wire             sub,
  output ldcr_pkg::acc_t  res,
  output logic            borrow
);

  logic [ldcr_pkg::ACC_W:0] full;

  always_comb begin
    if (sub) full = {1'b0, a} - {1'b0, b};
    else     full = {1'b0, a} + {1'b0, b};
    res    = full[ldcr_pkg::ACC_W-1:0];
    borrow = sub & full[ldcr_pkg::ACC_W];
  end

endmodule
`default_nettype wire

// ===== design/led_dot_circle_rasterizer_core.sv =====
// LED dot circle rasterizer, top level with its sequencer.
// Uses ldcr_pkg, the channel interfaces, ldcr_store and ldcr_alu.
//
// Requests arrive on in_ch, one result per request leaves on out_ch, and
// register writes arrive on cfg_ch, which is always ready.
// A write pixel request passes through IDLE and FIN, and a read pixel request
// through IDLE, RDP and FIN. A draw passes IDLE, CENTRE, RDC and MASK, then
// for every ring RING, a run of recurrence steps and NEXT; each step plots
// eight octant pixels in PLOT and makes three passes through the shared adder
// (ADDY, SUBX, CHK). A ring takes about a hundred steps whatever its size.
// The recurrence loop through the single adder dominates the time of a draw.
// in_ch is ready only while the sequencer is idle; a result waits in the
// output register while the receiver stalls, and the next request is taken
// meanwhile, although its own result then waits for the register to empty.
// After reset the frame store is cleared one pixel a cycle, and no request is
// taken until every pixel has been cleared.
`default_nettype none
module led_dot_circle_rasterizer_core #(
  parameter int FB_WIDTH  = ldcr_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = ldcr_pkg::FB_HEIGHT_DEF,
  parameter int DOT_COLS  = ldcr_pkg::DOT_COLS_DEF,
  parameter int DOT_ROWS  = ldcr_pkg::DOT_ROWS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  ldcr_req_if.sink    in_ch,
  ldcr_res_if.source  out_ch,
  ldcr_cfg_if.sink    cfg_ch
);

  localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  ldcr_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [11:0] gap_x_r, gap_y_r;
  logic [7:0]  rad_r;
  logic [5:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [23:0] colour_r, colour_nxt;
  logic        redraw_r, redraw_nxt;
  ldcr_pkg::coord_t cx_r, cx_nxt, cy_r, cy_nxt;
  logic        cin_r, cin_nxt;
  logic [2:0]  mask_r, mask_nxt;
  logic        clip_r, clip_nxt;
  logic [23:0] rd_r, rd_nxt;
  logic [4:0]  d_r, d_nxt;
  ldcr_pkg::acc_t xx_r, xx_nxt, yy_r, yy_nxt;
  logic [2:0]  oct_r, oct_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_rd_r, out_rd_nxt;
  logic [2:0]  out_mask_r, out_mask_nxt;
  logic        out_clip_r, out_clip_nxt;

  ldcr_pkg::store_ctl_t ctl;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [23:0] wdata, rdata;

  ldcr_pkg::acc_t alu_a, alu_b, alu_res;
  logic alu_sub, alu_borrow;

  ldcr_pkg::coord_t px, py, xo, yo;
  logic [19:0] sum_x, sum_y;
  logic [23:0] centre;
  logic in_acc;

  function automatic logic in_store(input ldcr_pkg::coord_t x,
                                    input ldcr_pkg::coord_t y);
    in_store = (x >= 0) && (y >= 0) &&
               (x < ldcr_pkg::coord_t'(FB_WIDTH)) &&
               (y < ldcr_pkg::coord_t'(FB_HEIGHT));
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input ldcr_pkg::coord_t x,
                                                input ldcr_pkg::coord_t y);
    addr_of = ADDR_W'(32'($unsigned(y)) * FB_WIDTH + 32'($unsigned(x)));
  endfunction

  ldcr_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  ldcr_alu u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .borrow(alu_borrow)
  );

  assign in_ch.ready  = (state_r == ldcr_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_blue  = out_rd_r[7:0];
  assign out_ch.read_green = out_rd_r[15:8];
  assign out_ch.read_red   = out_rd_r[23:16];
  assign out_ch.drawn_mask = out_mask_r;
  assign out_ch.clipped    = out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_x_r <= ldcr_pkg::GAP_X_RST;
      gap_y_r <= ldcr_pkg::GAP_Y_RST;
      rad_r   <= ldcr_pkg::RADIUS_RST;
    end else if (cfg_ch.valid) begin
      unique case (ldcr_pkg::cfg_idx_t'(cfg_ch.index))
        ldcr_pkg::CFG_GAP_X:  gap_x_r <= cfg_ch.data;
        ldcr_pkg::CFG_GAP_Y:  gap_y_r <= cfg_ch.data;
        ldcr_pkg::CFG_RADIUS: rad_r   <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    xo = ldcr_pkg::coord_t'(xx_r[39:35]);
    yo = ldcr_pkg::coord_t'(yy_r[39:35]);
    case (oct_r)
      3'd0:    begin px = cx_r + xo; py = cy_r + yo; end
      3'd1:    begin px = cx_r - xo; py = cy_r - yo; end
      3'd2:    begin px = cx_r - xo; py = cy_r + yo; end
      3'd3:    begin px = cx_r + xo; py = cy_r - yo; end
      3'd4:    begin px = cx_r + yo; py = cy_r + xo; end
      3'd5:    begin px = cx_r - yo; py = cy_r - xo; end
      3'd6:    begin px = cx_r - yo; py = cy_r + xo; end
      default: begin px = cx_r + yo; py = cy_r - xo; end
    endcase
    sum_x = 20'(gap_x_r) * 20'({1'b0, col_r} + 7'd1) +
            20'(rad_r) * 20'({col_r, 1'b1});
    sum_y = 20'(gap_y_r) * 20'({1'b0, row_r} + 6'd1) +
            20'(rad_r) * 20'({row_r, 1'b1});
    centre = cin_r ? rdata : 24'd0;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    colour_nxt    = colour_r;
    redraw_nxt    = redraw_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cin_nxt       = cin_r;
    mask_nxt      = mask_r;
    clip_nxt      = clip_r;
    rd_nxt        = rd_r;
    d_nxt         = d_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    oct_nxt       = oct_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rd_nxt    = out_rd_r;
    out_mask_nxt  = out_mask_r;
    out_clip_nxt  = out_clip_r;
    ctl           = '0;
    waddr         = addr_of(px, py);
    wdata         = colour_r;
    raddr         = addr_of(cx_r, cy_r);
    alu_a         = yy_r;
    alu_b         = xx_r >> 7;
    alu_sub       = 1'b0;

    unique case (state_r)
      ldcr_pkg::ST_CLEAR: begin
        ctl   = '{we: 1'b1, be: 3'b111};
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ldcr_pkg::ST_IDLE;
      end
      ldcr_pkg::ST_IDLE: begin
        if (in_acc) begin
          col_nxt    = in_ch.dot_col;
          row_nxt    = in_ch.dot_row;
          colour_nxt = {in_ch.red, in_ch.green, in_ch.blue};
          redraw_nxt = in_ch.redraw_all;
          mask_nxt   = '0;
          clip_nxt   = 1'b0;
          rd_nxt     = '0;
          cx_nxt     = ldcr_pkg::coord_t'(in_ch.pixel_x);
          cy_nxt     = ldcr_pkg::coord_t'(in_ch.pixel_y);
          unique case (ldcr_pkg::req_t'(in_ch.req_type))
            ldcr_pkg::REQ_DRAW: begin
              if (32'(in_ch.dot_col) >= DOT_COLS || 32'(in_ch.dot_row) >= DOT_ROWS) begin
                clip_nxt  = 1'b1;
                state_nxt = ldcr_pkg::ST_FIN;
              end else begin
                state_nxt = ldcr_pkg::ST_CENTRE;
              end
            end
            ldcr_pkg::REQ_READ: begin
              cin_nxt   = in_store(ldcr_pkg::coord_t'(in_ch.pixel_x),
                                   ldcr_pkg::coord_t'(in_ch.pixel_y));
              clip_nxt  = !cin_nxt;
              raddr     = addr_of(ldcr_pkg::coord_t'(in_ch.pixel_x),
                                  ldcr_pkg::coord_t'(in_ch.pixel_y));
              state_nxt = ldcr_pkg::ST_RDP;
            end
            ldcr_pkg::REQ_WRITE: begin
              waddr = addr_of(ldcr_pkg::coord_t'(in_ch.pixel_x),
                              ldcr_pkg::coord_t'(in_ch.pixel_y));
              wdata = {in_ch.red, in_ch.green, in_ch.blue};
              if (in_store(ldcr_pkg::coord_t'(in_ch.pixel_x),
                           ldcr_pkg::coord_t'(in_ch.pixel_y)))
                ctl = '{we: 1'b1, be: 3'b111};
              else
                clip_nxt = 1'b1;
              state_nxt = ldcr_pkg::ST_FIN;
            end
            default: state_nxt = ldcr_pkg::ST_FIN;
          endcase
        end
      end
      ldcr_pkg::ST_RDP: begin
        rd_nxt    = centre;
        state_nxt = ldcr_pkg::ST_FIN;
      end
      ldcr_pkg::ST_CENTRE: begin
        cx_nxt    = ldcr_pkg::coord_t'(sum_x[19:4]);
        cy_nxt    = ldcr_pkg::coord_t'(sum_y[19:4]);
        state_nxt = ldcr_pkg::ST_RDC;
      end
      ldcr_pkg::ST_RDC: begin
        cin_nxt   = in_store(cx_r, cy_r);
        if (!cin_nxt) clip_nxt = 1'b1;
        state_nxt = ldcr_pkg::ST_MASK;
      end
      ldcr_pkg::ST_MASK: begin
        if (redraw_r) mask_nxt = 3'b111;
        else mask_nxt = {centre[23:16] != colour_r[23:16],
                         centre[15:8] != colour_r[15:8],
                         centre[7:0] != colour_r[7:0]};
        d_nxt = rad_r[7:3];
        if (mask_nxt == 3'b000 || d_nxt == 5'd0) state_nxt = ldcr_pkg::ST_FIN;
        else state_nxt = ldcr_pkg::ST_RING;
      end
      ldcr_pkg::ST_RING: begin
        xx_nxt    = ldcr_pkg::acc_t'(d_r) << 34;
        yy_nxt    = '0;
        oct_nxt   = '0;
        state_nxt = ldcr_pkg::ST_PLOT;
      end
      ldcr_pkg::ST_PLOT: begin
        if (in_store(px, py)) ctl = '{we: 1'b1, be: mask_r};
        else clip_nxt = 1'b1;
        oct_nxt = oct_r + 3'd1;
        if (oct_r == 3'd7) state_nxt = ldcr_pkg::ST_ADDY;
      end
      ldcr_pkg::ST_ADDY: begin
        yy_nxt    = alu_res;
        state_nxt = ldcr_pkg::ST_SUBX;
      end
      ldcr_pkg::ST_SUBX: begin
        alu_a     = xx_r;
        alu_b     = yy_r >> 7;
        alu_sub   = 1'b1;
        xx_nxt    = alu_borrow ? '0 : alu_res;
        state_nxt = ldcr_pkg::ST_CHK;
      end
      ldcr_pkg::ST_CHK: begin
        alu_a     = xx_r;
        alu_b     = yy_r;
        alu_sub   = 1'b1;
        state_nxt = alu_borrow ? ldcr_pkg::ST_NEXT : ldcr_pkg::ST_PLOT;
      end
      ldcr_pkg::ST_NEXT: begin
        d_nxt     = (d_r >= 5'd2) ? d_r - 5'd2 : 5'd0;
        state_nxt = (d_nxt == 5'd0) ? ldcr_pkg::ST_FIN : ldcr_pkg::ST_RING;
      end
      ldcr_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_mask_nxt  = mask_r;
          out_clip_nxt  = clip_r;
          state_nxt     = ldcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ldcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ldcr_pkg::ST_CLEAR;
      clr_r       <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      oct_r       <= oct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    colour_r   <= colour_nxt;
    redraw_r   <= redraw_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cin_r      <= cin_nxt;
    mask_r     <= mask_nxt;
    clip_r     <= clip_nxt;
    rd_r       <= rd_nxt;
    d_r        <= d_nxt;
    xx_r       <= xx_nxt;
    yy_r       <= yy_nxt;
    out_rd_r   <= out_rd_nxt;
    out_mask_r <= out_mask_nxt;
    out_clip_r <= out_clip_nxt;
  end

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ldcr_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("request taken while the store is being cleared");

  a_oct_outside_plot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ldcr_pkg::ST_PLOT) |-> (oct_r == 3'd0))
    else $error("octant counter left non-zero outside plotting");

  a_read_or_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rd_r != 24'd0)) |-> (out_mask_r == 3'd0))
    else $error("result carries both read data and a drawn mask");

endmodule
`default_nettype wire

// ===== bench/led_dot_circle_rasterizer_core_tb.sv =====
// Self-checking testbench for led_dot_circle_rasterizer_core: it holds its own frame store and
// predicts draw, read and write requests, then checks each result in order.
// Depends on ldcr_pkg and the channel interfaces in ldcr_if.sv.
`timescale 1ns / 100ps
module led_dot_circle_rasterizer_core_tb;

  localparam int FBW = ldcr_pkg::FB_WIDTH_DEF;
  localparam int FBH = ldcr_pkg::FB_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    ldcr_pkg::req_t kind;
    logic [5:0] col;
    logic [4:0] row;
    logic [7:0] px;
    logic [6:0] py;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       redraw;
  } pix_req_t;

  typedef struct {
    logic [7:0] rb;
    logic [7:0] rg;
    logic [7:0] rr;
    logic [2:0] mask;
    logic       clip;
  } pix_res_t;

  logic clk;
  logic rst_n;
  ldcr_req_if in_ch();
  ldcr_res_if out_ch();
  ldcr_cfg_if cfg_ch();

  led_dot_circle_rasterizer_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [23:0] shadow_fb [0:FBW*FBH-1];
  logic [11:0] gap_x, gap_y;
  logic [7:0]  radius;

  pix_req_t pending_reqs[$];
  pix_res_t awaited_results[$];
  pix_req_t on_bus;
  int       send_idle_pct, recv_idle_pct;
  int       error_count;
  int       results_seen;
  int       hold_left;
  int       cycle_count;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic plot_pixel(int x, int y, logic [23:0] colour, logic [2:0] mask);
    logic [23:0] keep;
    if (x < 0 || y < 0 || x >= FBW || y >= FBH) return 1'b1;
    keep = {{8{mask[2]}}, {8{mask[1]}}, {8{mask[0]}}};
    shadow_fb[y*FBW + x] = (shadow_fb[y*FBW + x] & ~keep) | (colour & keep);
    return 1'b0;
  endfunction

  function automatic logic trace_ring(int cx, int cy, int d, logic [23:0] colour,
                                      logic [2:0] mask);
    longint unsigned xx, yy;
    int x, y;
    logic clip;
    xx = longint'(d) << 34;
    yy = 64'd0;
    clip = 1'b0;
    while (yy <= xx) begin
      x = int'(xx >> 35);
      y = int'(yy >> 35);
      clip |= plot_pixel(cx + x, cy + y, colour, mask);
      clip |= plot_pixel(cx - x, cy - y, colour, mask);
      clip |= plot_pixel(cx - x, cy + y, colour, mask);
      clip |= plot_pixel(cx + x, cy - y, colour, mask);
      clip |= plot_pixel(cx + y, cy + x, colour, mask);
      clip |= plot_pixel(cx - y, cy - x, colour, mask);
      clip |= plot_pixel(cx - y, cy + x, colour, mask);
      clip |= plot_pixel(cx + y, cy - x, colour, mask);
      yy += xx >> 7;
      if ((yy >> 7) > xx) xx = 64'd0;
      else xx -= yy >> 7;
    end
    return clip;
  endfunction

  function automatic pix_res_t predict_request(pix_req_t q);
    pix_res_t res;
    logic [23:0] colour, centre;
    int cx, cy, d;
    res = '{default: '0};
    colour = {q.r, q.g, q.b};
    case (q.kind)
      ldcr_pkg::REQ_DRAW: begin
        cx = (int'(gap_x) * (int'(q.col) + 1) + int'(radius) * (2 * int'(q.col) + 1)) >> 4;
        cy = (int'(gap_y) * (int'(q.row) + 1) + int'(radius) * (2 * int'(q.row) + 1)) >> 4;
        centre = '0;
        if (cx < FBW && cy < FBH) centre = shadow_fb[cy*FBW + cx];
        else res.clip = 1'b1;
        if (q.redraw) res.mask = 3'b111;
        else begin
          res.mask[0] = centre[7:0] != colour[7:0];
          res.mask[1] = centre[15:8] != colour[15:8];
          res.mask[2] = centre[23:16] != colour[23:16];
        end
        if (res.mask != 0) begin
          for (d = int'(radius) >> 3; d > 0; d = (d >= 2) ? d - 2 : 0)
            res.clip |= trace_ring(cx, cy, d, colour, res.mask);
        end
      end
      ldcr_pkg::REQ_READ: {res.rr, res.rg, res.rb} = shadow_fb[int'(q.py)*FBW + int'(q.px)];
      ldcr_pkg::REQ_WRITE: res.clip = plot_pixel(int'(q.px), int'(q.py), colour, 3'b111);
      default: ;
    endcase
    return res;
  endfunction

  // Request driver: a new request is presented once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) awaited_results.push_back(predict_request(on_bus));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= on_bus.kind;
          in_ch.dot_col <= on_bus.col;
          in_ch.dot_row <= on_bus.row;
          in_ch.pixel_x <= on_bus.px;
          in_ch.pixel_y <= on_bus.py;
          in_ch.blue <= on_bus.b;
          in_ch.green <= on_bus.g;
          in_ch.red <= on_bus.r;
          in_ch.redraw_all <= on_bus.redraw;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, counted here and started after 330 results.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      results_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (out_ch.valid && out_ch.ready && results_seen == 329) hold_left <= 3000;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    pix_res_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_ch.read_blue !== exp_res.rb) begin
            $error("read_blue: expected %0d, got %0d", exp_res.rb, out_ch.read_blue);
            error_count++;
          end
          if (out_ch.read_green !== exp_res.rg) begin
            $error("read_green: expected %0d, got %0d", exp_res.rg, out_ch.read_green);
            error_count++;
          end
          if (out_ch.read_red !== exp_res.rr) begin
            $error("read_red: expected %0d, got %0d", exp_res.rr, out_ch.read_red);
            error_count++;
          end
          if (out_ch.drawn_mask !== exp_res.mask) begin
            $error("drawn_mask: expected %0d, got %0d", exp_res.mask, out_ch.drawn_mask);
            error_count++;
          end
          if (out_ch.clipped !== exp_res.clip) begin
            $error("clipped: expected %0d, got %0d", exp_res.clip, out_ch.clipped);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_register(ldcr_pkg::cfg_idx_t idx, logic [11:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      ldcr_pkg::CFG_GAP_X: gap_x = value;
      ldcr_pkg::CFG_GAP_Y: gap_y = value;
      ldcr_pkg::CFG_RADIUS: radius = value[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_requests();
    while (pending_reqs.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_request(ldcr_pkg::req_t kind, int col, int row, int x, int y,
                               logic [23:0] colour, logic redraw);
    pix_req_t q;
    q.kind = kind;
    q.col = 6'(col);
    q.row = 5'(row);
    q.px = 8'(x);
    q.py = 7'(y);
    {q.r, q.g, q.b} = colour;
    q.redraw = redraw;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_random(int n);
    int roll;
    logic [23:0] colour;
    logic [23:0] palette [4];
    palette = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h123456};
    repeat (n) begin
      roll = $urandom_range(99);
      colour = ($urandom_range(1) != 0) ? palette[$urandom_range(3)] : 24'($urandom);
      if (roll < 30)
        queue_request(ldcr_pkg::REQ_DRAW, $urandom_range(63), $urandom_range(31),
                      $urandom_range(255), $urandom_range(127), colour,
                      $urandom_range(3) == 0);
      else if (roll < 62)
        queue_request(ldcr_pkg::REQ_READ, $urandom_range(63), $urandom_range(31),
                      $urandom_range(40), $urandom_range(40), colour,
                      $urandom_range(1) != 0);
      else if (roll < 95)
        queue_request(ldcr_pkg::REQ_WRITE, $urandom_range(63), $urandom_range(31),
                      $urandom_range(255), $urandom_range(127), colour,
                      $urandom_range(1) != 0);
      else
        queue_request(ldcr_pkg::REQ_NONE, $urandom_range(63), $urandom_range(31),
                      $urandom_range(255), $urandom_range(127), colour,
                      $urandom_range(1) != 0);
    end
  endtask

  task automatic random_settings();
    write_register(ldcr_pkg::CFG_GAP_X,
                   ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(64)));
    write_register(ldcr_pkg::CFG_GAP_Y,
                   ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(64)));
    write_register(ldcr_pkg::CFG_RADIUS, 12'($urandom_range(4, 40)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ldcr_pkg::REQ_NONE;
    in_ch.dot_col = '0;
    in_ch.dot_row = '0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.blue = '0;
    in_ch.green = '0;
    in_ch.red = '0;
    in_ch.redraw_all = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ldcr_pkg::CFG_GAP_X;
    cfg_ch.data = '0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    gap_x = ldcr_pkg::GAP_X_RST;
    gap_y = ldcr_pkg::GAP_Y_RST;
    radius = ldcr_pkg::RADIUS_RST;
    error_count = 0;
    results_seen = 0;
    hold_left = 0;
    cycle_count = 0;
    send_idle_pct = 38;
    recv_idle_pct = 57;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(ldcr_pkg::REQ_READ, 0, 0, 0, 0, 24'h0, 1'b0);
    queue_request(ldcr_pkg::REQ_WRITE, 0, 0, 0, 0, 24'hFFFFFF, 1'b0);
    queue_request(ldcr_pkg::REQ_WRITE, 63, 31, 255, 127, 24'hA5C3FF, 1'b1);
    queue_request(ldcr_pkg::REQ_READ, 0, 0, 0, 0, 24'h0, 1'b0);
    queue_request(ldcr_pkg::REQ_READ, 63, 31, 255, 127, 24'hFFFFFF, 1'b1);
    queue_request(ldcr_pkg::REQ_NONE, 63, 31, 255, 127, 24'hFFFFFF, 1'b1);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'h0000FF, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'h0000FF, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'h0000FF, 1'b1);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'hFF00FF, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 5, 3, 0, 0, 24'h000000, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 63, 31, 0, 0, 24'h00FF00, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 15, 7, 0, 0, 24'hFFFFFF, 1'b0);
    queue_request(ldcr_pkg::REQ_READ, 0, 0, 6, 2, 24'h0, 1'b0);
    queue_request(ldcr_pkg::REQ_READ, 0, 0, 4, 4, 24'h0, 1'b0);
    drain_requests();

    write_register(ldcr_pkg::CFG_GAP_X, 12'd0);
    write_register(ldcr_pkg::CFG_GAP_Y, 12'd0);
    write_register(ldcr_pkg::CFG_RADIUS, 12'd255);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'h804020, 1'b1);
    queue_request(ldcr_pkg::REQ_DRAW, 1, 0, 0, 0, 24'h112233, 1'b0);
    drain_requests();

    write_register(ldcr_pkg::CFG_GAP_X, 12'd4095);
    write_register(ldcr_pkg::CFG_GAP_Y, 12'd4095);
    write_register(ldcr_pkg::CFG_RADIUS, 12'd0);
    write_register(ldcr_pkg::CFG_UNUSED, 12'd4095);
    queue_request(ldcr_pkg::REQ_DRAW, 0, 0, 0, 0, 24'h00FF00, 1'b0);
    queue_request(ldcr_pkg::REQ_DRAW, 1, 1, 0, 0, 24'h0000FF, 1'b1);
    drain_requests();

    write_register(ldcr_pkg::CFG_RADIUS, 12'd7);
    write_register(ldcr_pkg::CFG_GAP_X, 12'd8);
    write_register(ldcr_pkg::CFG_GAP_Y, 12'd8);
    queue_request(ldcr_pkg::REQ_DRAW, 2, 2, 0, 0, 24'hFFFFFF, 1'b0);
    drain_requests();

    random_settings();
    queue_random(80);
    drain_requests();
    random_settings();
    queue_random(70);
    drain_requests();

    send_idle_pct = 57;
    recv_idle_pct = 38;
    random_settings();
    queue_random(75);
    drain_requests();
    random_settings();
    queue_random(75);
    drain_requests();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_settings();
    queue_random(75);
    drain_requests();
    random_settings();
    queue_random(75);
    drain_requests();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/ldcr_pkg.sv
design/ldcr_if.sv
design/ldcr_store.sv
design/ldcr_alu.sv
design/led_dot_circle_rasterizer_core.sv
bench/led_dot_circle_rasterizer_core_tb.sv
